[hdl/fsbp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsbp_pkg
// Shared types and constants of the fixed slot buffer pool: slot layout,
// operation codes and result status codes.
// ----------------------------------------------------------------------------
package fsbp_pkg;

   localparam int unsigned POOL_BYTES = 65536;
   localparam int unsigned SLOT_COUNT = 18;
   localparam int unsigned SLOT_IDX_W = $clog2(SLOT_COUNT);
   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned REQ_W      = 17;
   localparam int unsigned OFF_W      = 16;

   localparam logic OP_ALLOCATE = 1'b0;
   localparam logic OP_RELEASE  = 1'b1;

   typedef enum logic [2:0] {
      ST_GRANTED  = 3'd0,
      ST_FALLBACK = 3'd1,
      ST_RELEASED = 3'd2,
      ST_EXTERNAL = 3'd3,
      ST_UNKNOWN  = 3'd4
   } status_type;

   localparam logic [REQ_W-1:0] SLOT_SIZE [SLOT_COUNT] = '{
      17'd256,  17'd256,  17'd256,  17'd256,  17'd256,  17'd256,  17'd256,  17'd256,
      17'd1024, 17'd1024, 17'd1024, 17'd1024, 17'd1024, 17'd1024,
      17'd4096, 17'd4096,
      17'd16384,
      17'd32768
   };

   localparam logic [OFF_W-1:0] SLOT_OFFSET [SLOT_COUNT] = '{
      16'd0,     16'd256,   16'd512,   16'd768,   16'd1024,  16'd1280,  16'd1536,
      16'd1792,  16'd2048,  16'd3072,  16'd4096,  16'd5120,  16'd6144,  16'd7168,
      16'd8192,  16'd12288,
      16'd16384,
      16'd32768
   };

endpackage : fsbp_pkg
`default_nettype wire

[hdl/fixed_slot_buffer_pool.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_slot_buffer_pool
// Allocates and releases fixed slots of a 64 KiB pool at csr_pool_base.
// ----------------------------------------------------------------------------
// One transaction is taken every cycle unless req_stall is high, as when the
// input register is full and the result side stalls. A transaction is captured
// in an input register; from there the free flags of all 18 slots are checked
// in parallel (lowest fitting free slot for an allocate, start-address match
// for a release) and the outcome lands in the result register. The free flags
// are updated in the same cycle the transaction moves to the result register,
// so the next transaction always sees them. The user must keep csr_pool_base
// written only while the block is idle (unenforced); csr_ready is always high.
// ----------------------------------------------------------------------------
module fixed_slot_buffer_pool (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [fsbp_pkg::ADDR_W-1:0]   csr_pool_base,

   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic                          req_operation,
   input  wire logic [fsbp_pkg::REQ_W-1:0]    req_request_bytes,
   input  wire logic [fsbp_pkg::ADDR_W-1:0]   req_release_address,

   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      fsbp_pkg::status_type          rsp_status,
   output      logic [fsbp_pkg::ADDR_W-1:0]   rsp_granted_address
);
   import fsbp_pkg::*;

   logic [ADDR_W-1:0]     pool_base_ff, pool_base_in;
   logic [SLOT_COUNT-1:0] slot_free_ff, slot_free_in;

   logic                  in_valid_ff, in_valid_in;
   logic                  in_op_ff, in_op_in;
   logic [REQ_W-1:0]      in_req_ff, in_req_in;
   logic [ADDR_W-1:0]     in_addr_ff, in_addr_in;

   logic                  out_valid_ff, out_valid_in;
   status_type            out_status_ff, out_status_in;
   logic [ADDR_W-1:0]     out_addr_ff, out_addr_in;

   logic                  advance;
   logic                  accept;
   logic [REQ_W-1:0]      req_sat;
   logic [SLOT_COUNT-1:0] fit_free;
   logic                  grant_hit;
   logic [SLOT_IDX_W-1:0] grant_idx;
   logic [ADDR_W-1:0]     rel_off;
   logic                  rel_external;
   logic                  rel_hit;
   logic [SLOT_IDX_W-1:0] rel_idx;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // allocate: lowest free slot that fits
   always_comb begin
      req_sat = (in_req_ff > REQ_W'(POOL_BYTES)) ? REQ_W'(POOL_BYTES) : in_req_ff;
      grant_hit = 1'b0;
      grant_idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         fit_free[i] = slot_free_ff[i] && (SLOT_SIZE[i] >= req_sat);
         if (fit_free[i]) begin
            grant_hit = 1'b1;
            grant_idx = SLOT_IDX_W'(i);
         end
      end
   end

   // release: slot start match inside [base, base + POOL_BYTES)
   always_comb begin
      rel_off      = in_addr_ff - pool_base_ff;
      rel_external = (rel_off[ADDR_W-1:OFF_W] != '0);
      rel_hit      = 1'b0;
      rel_idx      = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (rel_off[OFF_W-1:0] == SLOT_OFFSET[i]) begin
            rel_hit = 1'b1;
            rel_idx = SLOT_IDX_W'(i);
         end
      end
   end

   always_comb begin
      pool_base_in  = pool_base_ff;
      slot_free_in  = slot_free_ff;
      in_valid_in   = in_valid_ff;
      in_op_in      = in_op_ff;
      in_req_in     = in_req_ff;
      in_addr_in    = in_addr_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_addr_in   = out_addr_ff;

      if (csr_valid && csr_ready) begin
         pool_base_in = csr_pool_base;
      end

      if (advance) begin
         out_valid_in = in_valid_ff;
         out_addr_in  = '0;
         if (in_op_ff == OP_ALLOCATE) begin
            if (grant_hit) begin
               out_status_in = ST_GRANTED;
               out_addr_in   = pool_base_ff + ADDR_W'(SLOT_OFFSET[grant_idx]);
               if (in_valid_ff) begin
                  slot_free_in[grant_idx] = 1'b0;
               end
            end else begin
               out_status_in = ST_FALLBACK;
            end
         end else begin
            if (rel_external) begin
               out_status_in = ST_EXTERNAL;
            end else if (rel_hit) begin
               out_status_in = ST_RELEASED;
               if (in_valid_ff) begin
                  slot_free_in[rel_idx] = 1'b1;
               end
            end else begin
               out_status_in = ST_UNKNOWN;
            end
         end
         in_valid_in = 1'b0;
      end

      if (accept) begin
         in_valid_in = 1'b1;
         in_op_in    = req_operation;
         in_req_in   = req_request_bytes;
         in_addr_in  = req_release_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= '0;
         slot_free_ff <= '1;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pool_base_ff <= pool_base_in;
         slot_free_ff <= slot_free_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_op_ff      <= in_op_in;
      in_req_ff     <= in_req_in;
      in_addr_ff    <= in_addr_in;
      out_status_ff <= out_status_in;
      out_addr_ff   <= out_addr_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_granted_address = out_addr_ff;

   a_addr_zero_unless_grant : assert property (
      @(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff != ST_GRANTED) |-> (out_addr_ff == '0)
   ) else $error("granted address not zero on a non-grant result");

   a_grant_takes_one_slot : assert property (
      @(posedge clock) disable iff (reset)
      (advance && in_valid_ff && in_op_ff == OP_ALLOCATE && grant_hit)
      |=> ($countones(slot_free_ff) + 1 == $past($countones(slot_free_ff)))
   ) else $error("grant did not claim exactly one slot");

   a_release_never_claims : assert property (
      @(posedge clock) disable iff (reset)
      (advance && in_valid_ff && in_op_ff == OP_RELEASE)
      |=> ($countones(slot_free_ff) >= $past($countones(slot_free_ff)))
   ) else $error("release reduced the free slot count");

   a_grant_slot_was_free : assert property (
      @(posedge clock) disable iff (reset)
      (in_valid_ff && in_op_ff == OP_ALLOCATE && grant_hit) |-> slot_free_ff[grant_idx]
   ) else $error("grant selected a slot that is not free");

endmodule : fixed_slot_buffer_pool
`default_nettype wire
